// ===== hw/rtl/skt_pkg.sv =====
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types, constants and the SipRound function for the keyed tag block.
// ----------------------------------------------------------------------------
package skt_pkg;

  typedef logic [63:0] word_t;
  typedef word_t [3:0] sip_state_t;
  typedef logic [3:0]  rnd_cnt_t;

  localparam word_t SIP_C0  = 64'h736F6D6570736575;
  localparam word_t SIP_C1  = 64'h646F72616E646F6D;
  localparam word_t SIP_C2  = 64'h6C7967656E657261;
  localparam word_t SIP_C3  = 64'h7465646279746573;
  localparam word_t FIN_XOR = 64'h00000000000000FF;

  localparam int CFG_IDX_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_LOW  = 8'd0,
    REG_KEY_HIGH = 8'd1,
    REG_C_ROUNDS = 8'd2,
    REG_D_ROUNDS = 8'd3
  } reg_idx_t;

  typedef struct packed {
    logic load;
    logic rnd;
    logic xor_v0;
    logic xor_v2;
    logic len_blk;
    logic tag_ld;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic full;
    logic in_msg;
  } sts_t;

  function automatic word_t rotl(input word_t x, input int r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic sip_state_t sip_round(input sip_state_t v);
    word_t a, b, c, d;
    a = v[0];
    b = v[1];
    c = v[2];
    d = v[3];
    a = a + b;
    c = c + d;
    b = rotl(b, 13);
    d = rotl(d, 16);
    b = b ^ a;
    d = d ^ c;
    a = rotl(a, 32);
    c = c + b;
    a = a + d;
    b = rotl(b, 17);
    d = rotl(d, 21);
    b = b ^ c;
    d = d ^ a;
    c = rotl(c, 32);
    return {d, c, b, a};
  endfunction

endpackage

// ===== hw/rtl/skt_dp.sv =====
// ----------------------------------------------------------------------------
// skt_dp
// Datapath: SipHash state, current block, length byte and tag register.
// ----------------------------------------------------------------------------
module skt_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  skt_pkg::cmd_t  cmd,
  input  logic           in_action,
  input  logic [63:0]    in_word,
  input  logic [3:0]     in_count,
  input  logic           in_last,
  input  logic [63:0]    in_expected,
  input  logic [63:0]    key_low,
  input  logic [63:0]    key_high,
  output skt_pkg::sts_t  sts,
  output logic [63:0]    tag,
  output logic           tag_matches
);
  import skt_pkg::*;

  sip_state_t v_r, v_nxt, rv, v_init;
  word_t      msg_r, masked, blk, len_word, tag_nxt;
  logic [7:0] len_r, len_nxt;
  logic [3:0] cnt_sat;
  logic       full_in;
  logic       act_r, last_r, full_r, in_msg_r, match_r;
  word_t      exp_r, tag_r;

  always_comb begin
    cnt_sat = (in_count > 4'd8) ? 4'd8 : in_count;
    for (int b = 0; b < 8; b++) begin
      masked[b*8 +: 8] = (4'(b) < cnt_sat) ? in_word[b*8 +: 8] : 8'h00;
    end
    full_in  = (cnt_sat == 4'd8);
    len_nxt  = (in_msg_r ? len_r : 8'd0) + {4'd0, cnt_sat};
    blk      = masked | ((in_last && !full_in) ? {len_nxt, 56'd0} : 64'd0);
    len_word = {len_r, 56'd0};
    tag_nxt  = v_r[0] ^ v_r[1] ^ v_r[2] ^ v_r[3];

    v_init[0] = SIP_C0 ^ key_low;
    v_init[1] = SIP_C1 ^ key_high;
    v_init[2] = SIP_C2 ^ key_low;
    v_init[3] = SIP_C3 ^ key_high;

    rv    = cmd.rnd ? sip_round(v_r) : v_r;
    v_nxt = rv;
    if (cmd.xor_v0) begin
      v_nxt[0] = rv[0] ^ msg_r;
    end
    if (cmd.xor_v2) begin
      v_nxt[2] = rv[2] ^ FIN_XOR;
    end
    if (cmd.len_blk) begin
      v_nxt[3] = v_r[3] ^ len_word;
    end
    if (cmd.load) begin
      v_nxt    = in_msg_r ? v_r : v_init;
      v_nxt[3] = v_nxt[3] ^ blk;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_msg_r <= 1'b0;
    end else if (cmd.load) begin
      in_msg_r <= 1'b1;
    end else if (cmd.tag_ld) begin
      in_msg_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
    if (cmd.load) begin
      msg_r  <= blk;
      len_r  <= len_nxt;
      act_r  <= in_action;
      exp_r  <= in_expected;
      last_r <= in_last;
      full_r <= full_in;
    end
    if (cmd.len_blk) begin
      msg_r  <= len_word;
      full_r <= 1'b0;
    end
    if (cmd.tag_ld) begin
      tag_r   <= tag_nxt;
      match_r <= act_r && (tag_nxt == exp_r);
    end
  end

  assign sts.last    = last_r;
  assign sts.full    = full_r;
  assign sts.in_msg  = in_msg_r;
  assign tag         = tag_r;
  assign tag_matches = match_r;

endmodule

// ===== hw/rtl/skt_ctrl.sv =====
// ----------------------------------------------------------------------------
// skt_ctrl
// Controller: sequences load, compression, length block, finalization, tag.
// ----------------------------------------------------------------------------
module skt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  skt_pkg::rnd_cnt_t c_rounds,
  input  skt_pkg::rnd_cnt_t d_rounds,
  input  skt_pkg::sts_t     sts,
  output skt_pkg::cmd_t     cmd
);
  import skt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COMP,
    S_LEN,
    S_FIN,
    S_DONE
  } state_t;

  state_t   state_r, state_nxt;
  rnd_cnt_t cnt_r, cnt_nxt;
  logic     out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_tready = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_COMP;
        end
      end
      S_COMP: begin
        if (c_rounds != 4'd0) begin
          cmd.rnd = 1'b1;
          cnt_nxt = cnt_r + 4'd1;
        end
        if (c_rounds == 4'd0 || cnt_r == c_rounds - 4'd1) begin
          cmd.xor_v0 = 1'b1;
          cnt_nxt    = '0;
          priority if (!sts.last) begin
            state_nxt = S_IDLE;
          end else if (sts.full) begin
            state_nxt = S_LEN;
          end else begin
            cmd.xor_v2 = 1'b1;
            state_nxt  = S_FIN;
          end
        end
      end
      S_LEN: begin
        cmd.len_blk = 1'b1;
        state_nxt   = S_COMP;
      end
      S_FIN: begin
        if (d_rounds == 4'd0) begin
          state_nxt = S_DONE;
        end else begin
          cmd.rnd = 1'b1;
          cnt_nxt = cnt_r + 4'd1;
          if (cnt_r == d_rounds - 4'd1) begin
            cnt_nxt   = '0;
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.tag_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = cmd.tag_ld | (out_valid_r & ~out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// ===== hw/rtl/siphash_keyed_tag.sv =====
// ----------------------------------------------------------------------------
// siphash_keyed_tag
// Keyed SipHash-c-d tag over a stream of little-endian 64-bit message words.
// ----------------------------------------------------------------------------
// Channel  Direction  Moves
// in_      slave      one message word request (tlast ends the message)
// out_     master     one tag per message, verify flag in tuser
// cfg_     slave      register write: key words and round counts
//
// Per word: a load step in S_IDLE, then c SipRounds in S_COMP.
// Full last word: a length-block step in S_LEN, then c more SipRounds.
// Last word then adds d SipRounds in S_FIN and a tag step in S_DONE.
// One SipRound unit runs one round per cycle; all rounds go through it.
// A pending tag holds while the next message is taken; its tag cycle waits.
// Reset is synchronous; no clearing pass.
// ----------------------------------------------------------------------------
module siphash_keyed_tag (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [63:0] message_word, [67:64] byte_count, [131:68] expected_tag, zero pad
  input  logic [135:0] in_tdata,
  // [0] action
  input  logic         in_tuser,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [63:0] tag
  output logic [63:0]  out_tdata,
  // [0] tag_matches
  output logic         out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [63:0]  cfg_data
);
  import skt_pkg::*;

  word_t    key_low_r, key_high_r;
  rnd_cnt_t c_rounds_r, d_rounds_r;
  cmd_t     cmd;
  sts_t     sts;
  logic     cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
      c_rounds_r <= 4'd2;
      d_rounds_r <= 4'd4;
    end else if (cfg_wr) begin
      if (cfg_index == REG_KEY_LOW) begin
        key_low_r <= cfg_data;
      end
      if (cfg_index == REG_KEY_HIGH) begin
        key_high_r <= cfg_data;
      end
      if (cfg_index == REG_C_ROUNDS) begin
        c_rounds_r <= cfg_data[3:0];
      end
      if (cfg_index == REG_D_ROUNDS) begin
        d_rounds_r <= cfg_data[3:0];
      end
    end
  end

  skt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .c_rounds   (c_rounds_r),
    .d_rounds   (d_rounds_r),
    .sts        (sts),
    .cmd        (cmd)
  );

  skt_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_action   (in_tuser),
    .in_word     (in_tdata[63:0]),
    .in_count    (in_tdata[67:64]),
    .in_last     (in_tlast),
    .in_expected (in_tdata[131:68]),
    .key_low     (key_low_r),
    .key_high    (key_high_r),
    .sts         (sts),
    .tag         (out_tdata),
    .tag_matches (out_tuser)
  );

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after a request");

  a_tag_ld_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tag_ld |-> (!out_tvalid || out_tready))
    else $error("tag overwritten while pending");

  a_load_opens_msg: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> sts.in_msg)
    else $error("message not open after load");

endmodule
